// ===== sv/bmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmd_pkg - shared types and constants of the bus message deframer
// Frame phases, result kind codes, header layout and the word types that
// move between the deframer stages.
// ----------------------------------------------------------------------------
package bmd_pkg;

	// frame phase
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	// result kinds
	localparam logic [2:0] KIND_JOIN    = 3'd0;
	localparam logic [2:0] KIND_LEAVE   = 3'd1;
	localparam logic [2:0] KIND_PAYLOAD = 3'd2;
	localparam logic [2:0] KIND_EMPTY   = 3'd3;
	localparam logic [2:0] KIND_ABORT   = 3'd4;

	// message types carried in the header type word
	localparam logic [31:0] TYPE_JOIN  = 32'd1;
	localparam logic [31:0] TYPE_LEAVE = 32'd2;
	localparam logic [31:0] TYPE_DATA  = 32'd3;

	// header is three 32-bit words, length word follows
	localparam logic [3:0] HEADER_LAST = 4'd11;
	localparam logic [3:0] LENGTH_LAST = 4'd15;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
		logic       link_lost;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  msg_kind;
		logic [31:0] peer_first;
		logic [31:0] peer_second;
		logic [7:0]  payload_byte;
		logic        first_of_message;
		logic        last_of_message;
	} out_word_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} result_t;

	// place one little-endian byte into a 32-bit word
	function automatic logic [31:0] insert_byte(logic [31:0] w, logic [1:0] idx,
			logic [7:0] b);
		return w | (32'(b) << {idx, 3'b000});
	endfunction

endpackage

// ===== sv/bmd_in_if.sv =====
// ----------------------------------------------------------------------------
// bmd_in_if - received byte channel
// Valid/ready channel carrying one received stream byte and its flags.
// ----------------------------------------------------------------------------
interface bmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       chunk_end;
	logic       link_lost;

	modport source (output valid, output rx_byte, output chunk_end, output link_lost,
		input ready);
	modport sink (input valid, input rx_byte, input chunk_end, input link_lost,
		output ready);
endinterface

// ===== sv/bmd_out_if.sv =====
// ----------------------------------------------------------------------------
// bmd_out_if - deframed message channel
// Valid/ready channel carrying one deframer result word.
// ----------------------------------------------------------------------------
interface bmd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  msg_kind;
	logic [31:0] peer_first;
	logic [31:0] peer_second;
	logic [7:0]  payload_byte;
	logic        first_of_message;
	logic        last_of_message;

	modport source (output valid, output msg_kind, output peer_first, output peer_second,
		output payload_byte, output first_of_message, output last_of_message,
		input ready);
	modport sink (input valid, input msg_kind, input peer_first, input peer_second,
		input payload_byte, input first_of_message, input last_of_message,
		output ready);
endinterface

// ===== sv/bmd_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// bmd_frame_fsm - frame state machine
// Holds the frame state, decodes one byte per step and forms the result.
// ----------------------------------------------------------------------------
module bmd_frame_fsm
	import bmd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_word_t word,
	output result_t  result
);

	phase_t      phase_q, phase_nx;
	logic [3:0]  count_q, count_nx;
	logic [31:0] type_q, type_nx;
	logic [31:0] peer_a_q, peer_a_nx;
	logic [31:0] peer_b_q, peer_b_nx;
	logic [31:0] remain_q, remain_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			count_q  <= '0;
			type_q   <= '0;
			peer_a_q <= '0;
			peer_b_q <= '0;
			remain_q <= '0;
		end else if (step) begin
			phase_q  <= phase_nx;
			count_q  <= count_nx;
			type_q   <= type_nx;
			peer_a_q <= peer_a_nx;
			peer_b_q <= peer_b_nx;
			remain_q <= remain_nx;
		end
	end

	always_comb begin
		logic clear;
		logic last;
		clear     = 1'b0;
		last      = 1'b0;
		phase_nx  = phase_q;
		count_nx  = count_q;
		type_nx   = type_q;
		peer_a_nx = peer_a_q;
		peer_b_nx = peer_b_q;
		remain_nx = remain_q;
		result.valid                 = 1'b0;
		result.word.msg_kind         = KIND_JOIN;
		result.word.peer_first       = peer_a_q;
		result.word.peer_second      = peer_b_q;
		result.word.payload_byte     = '0;
		result.word.first_of_message = 1'b0;
		result.word.last_of_message  = 1'b0;

		if (word.link_lost) begin
			if (phase_q == PH_PAYLOAD) begin
				result.valid         = 1'b1;
				result.word.msg_kind = KIND_ABORT;
			end
			clear = 1'b1;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					case (count_q[3:2])
						2'd0:    type_nx   = insert_byte(type_q, count_q[1:0], word.rx_byte);
						2'd1:    peer_a_nx = insert_byte(peer_a_q, count_q[1:0], word.rx_byte);
						default: peer_b_nx = insert_byte(peer_b_q, count_q[1:0], word.rx_byte);
					endcase
					count_nx = count_q + 4'd1;
					if (count_q >= HEADER_LAST) begin
						// type word is complete after the fourth byte
						if (type_q == TYPE_JOIN || type_q == TYPE_LEAVE) begin
							result.valid            = 1'b1;
							result.word.msg_kind    = (type_q == TYPE_JOIN) ? KIND_JOIN
								: KIND_LEAVE;
							result.word.peer_second = peer_b_nx;
							clear = 1'b1;
						end else if (type_q == TYPE_DATA) begin
							phase_nx  = PH_LENGTH;
							remain_nx = '0;
						end else if (word.chunk_end) begin
							clear = 1'b1;
						end else begin
							phase_nx = PH_DISCARD;
						end
					end
				end
				PH_LENGTH: begin
					remain_nx = insert_byte(remain_q, count_q[1:0], word.rx_byte);
					count_nx  = count_q + 4'd1;
					if (count_q == LENGTH_LAST) begin
						if (remain_nx == '0) begin
							result.valid         = 1'b1;
							result.word.msg_kind = KIND_EMPTY;
							clear = 1'b1;
						end else begin
							phase_nx = PH_PAYLOAD;
							count_nx = '0;
						end
					end
				end
				PH_PAYLOAD: begin
					last = (remain_q <= 32'd1);
					result.valid                 = 1'b1;
					result.word.msg_kind         = KIND_PAYLOAD;
					result.word.payload_byte     = word.rx_byte;
					result.word.first_of_message = (count_q == '0);
					result.word.last_of_message  = last;
					count_nx  = 4'd1;
					remain_nx = remain_q - 32'd1;
					clear     = last;
				end
				PH_DISCARD: begin
					clear = word.chunk_end;
				end
				default: clear = 1'b1;
			endcase
		end

		if (clear) begin
			phase_nx  = PH_HEADER;
			count_nx  = '0;
			type_nx   = '0;
			peer_a_nx = '0;
			peer_b_nx = '0;
			remain_nx = '0;
		end
	end

endmodule

// ===== sv/bmd_out_queue.sv =====
// ----------------------------------------------------------------------------
// bmd_out_queue - result register pair
// Two-entry queue between the frame logic and the output channel.
// ----------------------------------------------------------------------------
module bmd_out_queue
	import bmd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_word_t push_word,
	output logic      has_room,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	out_word_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign has_room  = (count_q != 2'd2);
	assign pop       = out_valid && out_ready;
	assign out_word  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== sv/bus_message_deframer.sv =====
// ----------------------------------------------------------------------------
// bus_message_deframer - received byte stream deframer
// Gathers 12-byte headers and streams join, leave, payload, empty and abort
// results from the received bytes.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while the result queue has room and
// gives at most one result word per byte. Each byte is captured in an input
// register, decoded against the frame state once the result queue has room
// and written into a two-entry result queue, which offers its head on msg.
// The sustained rate is one byte per cycle while the result sink keeps up;
// the result queue depth sets how long rx stays ready when msg stalls (two
// pending results).
// Header and length words are little-endian. Payload bytes stream out with
// first and last marks; link loss mid-payload gives an abort word carrying
// the peer id of the broken frame. No clearing pass after reset.
// ----------------------------------------------------------------------------
module bus_message_deframer
	import bmd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bmd_in_if.sink     rx,
	bmd_out_if.source  msg
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      advance;
	logic      has_room;
	logic      accept;
	result_t   result;
	out_word_t head;

	// a byte in s1 moves on whenever the queue can take any result it makes
	assign advance  = valid_s1 && has_room;
	assign rx.ready = !valid_s1 || advance;
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.rx_byte   <= rx.rx_byte;
			word_s1.chunk_end <= rx.chunk_end;
			word_s1.link_lost <= rx.link_lost;
		end
	end

	bmd_frame_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.result (result)
	);

	bmd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && result.valid),
		.push_word (result.word),
		.has_room  (has_room),
		.out_valid (msg.valid),
		.out_ready (msg.ready),
		.out_word  (head)
	);

	assign msg.msg_kind         = head.msg_kind;
	assign msg.peer_first       = head.peer_first;
	assign msg.peer_second      = head.peer_second;
	assign msg.payload_byte     = head.payload_byte;
	assign msg.first_of_message = head.first_of_message;
	assign msg.last_of_message  = head.last_of_message;

endmodule

// ===== bench/bmd_msg_checker.sv =====
// ----------------------------------------------------------------------------
// bmd_msg_checker - result checker for the bus message deframer
// Watches both channels. Each accepted rx word goes through a deframer
// predictor whose expected msg words are queued and compared in order with
// the words the block hands out.
// ----------------------------------------------------------------------------
module bmd_msg_checker
	import bmd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bmd_in_if           rx,
	bmd_out_if          msg,
	output int unsigned fail_count,
	output int unsigned pending
);

	localparam int unsigned MAX_PRINTED = 100;

	// predictor frame state
	phase_t      frame_phase;
	logic [3:0]  byte_idx;
	logic [31:0] type_acc;
	logic [31:0] peer_a;
	logic [31:0] peer_b;
	logic [31:0] len_left;

	out_word_t   want_msgs[$];
	out_word_t   want;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string line);
		if (fail_count < MAX_PRINTED)
			$display("msg check @%0t: %s", $time, line);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, exp_val));
	endtask

	function automatic logic [31:0] put_byte(input logic [31:0] acc, input logic [3:0] idx,
			input logic [7:0] b);
		return acc | ({24'd0, b} << (8 * idx[1:0]));
	endfunction

	task automatic restart_frame();
		frame_phase = PH_HEADER;
		byte_idx    = '0;
		type_acc    = '0;
		peer_a      = '0;
		peer_b      = '0;
		len_left    = '0;
	endtask

	task automatic queue_msg(input logic [2:0] kind, input logic [7:0] b,
			input logic is_first, input logic is_last);
		out_word_t w;
		w.msg_kind         = kind;
		w.peer_first       = peer_a;
		w.peer_second      = peer_b;
		w.payload_byte     = b;
		w.first_of_message = is_first;
		w.last_of_message  = is_last;
		want_msgs.insert(want_msgs.size(), w);
	endtask

	// one received byte through the deframer
	task automatic deframe_byte(input in_word_t w);
		logic is_first;
		logic is_last;
		if (w.link_lost) begin
			if (frame_phase == PH_PAYLOAD)
				queue_msg(KIND_ABORT, 8'h00, 1'b0, 1'b0);
			restart_frame();
		end else begin
			case (frame_phase)
				PH_HEADER: begin
					if (byte_idx < 4'd4)
						type_acc = put_byte(type_acc, byte_idx, w.rx_byte);
					else if (byte_idx < 4'd8)
						peer_a = put_byte(peer_a, byte_idx, w.rx_byte);
					else
						peer_b = put_byte(peer_b, byte_idx, w.rx_byte);
					if (byte_idx == HEADER_LAST) begin
						byte_idx = byte_idx + 4'd1;
						if (type_acc == TYPE_JOIN || type_acc == TYPE_LEAVE) begin
							queue_msg((type_acc == TYPE_JOIN) ? KIND_JOIN : KIND_LEAVE,
								8'h00, 1'b0, 1'b0);
							restart_frame();
						end else if (type_acc == TYPE_DATA) begin
							frame_phase = PH_LENGTH;
							len_left    = '0;
						end else if (w.chunk_end) begin
							restart_frame();
						end else begin
							frame_phase = PH_DISCARD;
						end
					end else begin
						byte_idx = byte_idx + 4'd1;
					end
				end
				PH_LENGTH: begin
					len_left = put_byte(len_left, byte_idx, w.rx_byte);
					if (byte_idx == LENGTH_LAST) begin
						if (len_left == '0) begin
							queue_msg(KIND_EMPTY, 8'h00, 1'b0, 1'b0);
							restart_frame();
						end else begin
							frame_phase = PH_PAYLOAD;
							byte_idx    = '0;
						end
					end else begin
						byte_idx = byte_idx + 4'd1;
					end
				end
				PH_PAYLOAD: begin
					is_first = (byte_idx == '0);
					is_last  = (len_left <= 32'd1);
					queue_msg(KIND_PAYLOAD, w.rx_byte, is_first, is_last);
					byte_idx = 4'd1;
					if (is_last)
						restart_frame();
					else
						len_left = len_left - 32'd1;
				end
				default: begin
					if (w.chunk_end)
						restart_frame();
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_frame();
			want_msgs.delete();
			pending <= 0;
		end else begin
			if (rx.valid && rx.ready)
				deframe_byte({rx.rx_byte, rx.chunk_end, rx.link_lost});
			if (msg.valid && msg.ready) begin
				if (want_msgs.size() == 0) begin
					report_mismatch($sformatf("unexpected msg word kind %0d", msg.msg_kind));
				end else begin
					want = want_msgs.pop_front();
					check_field("msg_kind", 32'(msg.msg_kind), 32'(want.msg_kind));
					check_field("peer_first", msg.peer_first, want.peer_first);
					check_field("peer_second", msg.peer_second, want.peer_second);
					check_field("payload_byte", 32'(msg.payload_byte),
						32'(want.payload_byte));
					check_field("first_of_message", 32'(msg.first_of_message),
						32'(want.first_of_message));
					check_field("last_of_message", 32'(msg.last_of_message),
						32'(want.last_of_message));
				end
			end
			pending <= want_msgs.size();
		end
	end

endmodule

// ===== bench/tb_bus_message_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_bus_message_deframer - testbench of the bus message deframer
// Feeds directed frames and then a long random mix of join, leave, data,
// unknown-type, cut-short and noise frames with random gaps on rx and random
// stalls on msg; a checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_bus_message_deframer;
	import bmd_pkg::*;

	localparam int          HALF_PERIOD  = 10;
	localparam int unsigned RESET_CYCLES = 7;
	localparam int unsigned RANDOM_BYTES = 750;
	localparam int unsigned MAX_GAP      = 14;
	// length of the long msg hold-offs that fill the result queue and the input register
	localparam int unsigned LONG_HOLD    = 300;
	// drain time that catches stray words after the last expected one
	localparam int unsigned DRAIN_CYCLES = 16;
	// slowest legal run: every byte with a full gap plus one result behind a full
	// stall, plus two long holds; the limit lies well above it
	localparam int unsigned RUN_LIMIT    = 200000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fails;
	int unsigned outstanding;

	// planned rx words, built up front and then sent in order
	in_word_t    byte_plan[$];

	bmd_in_if  rx_ch();
	bmd_out_if msg_ch();

	bus_message_deframer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.msg    (msg_ch)
	);

	bmd_msg_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.msg        (msg_ch),
		.fail_count (fails),
		.pending    (outstanding)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// chunk_end set on about one byte in four
	function automatic logic rand_cend();
		return ($urandom_range(0, 3) == 0);
	endfunction

	// any type word except join, leave and data
	function automatic logic [31:0] rand_unknown_type();
		logic [31:0] t;
		t = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 15);
		if (t == TYPE_JOIN || t == TYPE_LEAVE || t == TYPE_DATA)
			t = t + 32'd4;
		return t;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic cend, input logic lost);
		in_word_t w;
		w.rx_byte   = b;
		w.chunk_end = cend;
		w.link_lost = lost;
		byte_plan.insert(byte_plan.size(), w);
	endtask

	task automatic push_lost();
		push_byte(8'($urandom_range(0, 255)), rand_cend(), 1'b1);
	endtask

	// first upto bytes of a little-endian header; last_cend goes on byte 11
	task automatic push_header(input logic [31:0] t, input logic [31:0] pa,
			input logic [31:0] pb, input logic last_cend, input int unsigned upto);
		logic [95:0] hdr;
		int unsigned i;
		hdr = {pb, pa, t};
		for (i = 0; i < upto; i++)
			push_byte(hdr[8*i +: 8], (i == 11) ? last_cend : rand_cend(), 1'b0);
	endtask

	// data frame; if fewer than len bytes are sent the link drops mid-payload
	task automatic plan_data_frame(input logic [31:0] pa, input logic [31:0] pb,
			input logic [31:0] len, input logic [31:0] sent);
		logic [31:0] k;
		push_header(TYPE_DATA, pa, pb, rand_cend(), 12);
		for (k = 0; k < 4; k++)
			push_byte(len[8*k +: 8], rand_cend(), 1'b0);
		for (k = 0; k < sent && k < len; k++)
			push_byte(8'($urandom_range(0, 255)), rand_cend(), 1'b0);
		if (sent < len)
			push_lost();
	endtask

	// unknown type: skip == 0 ends the chunk on the header's last byte,
	// otherwise skip bytes are discarded, the last of them ending the chunk
	task automatic push_unknown(input logic [31:0] t, input logic [31:0] pa,
			input logic [31:0] pb, input int unsigned skip);
		push_header(t, pa, pb, (skip == 0), 12);
		if (skip > 0) begin
			repeat (skip - 1)
				push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// rx side: plan the stream, release reset, then send word by word
	// ------------------------------------------------------------------------
	initial begin : rx_stimulus
		int unsigned directed_n;
		int unsigned pick;
		int unsigned cut;
		int unsigned gap;
		int unsigned i;
		int unsigned n;
		logic [31:0] pa;
		logic [31:0] pb;
		logic [31:0] len;
		logic [31:0] sent;
		in_word_t    w;

		rx_ch.valid     <= 1'b0;
		rx_ch.rx_byte   <= '0;
		rx_ch.chunk_end <= 1'b0;
		rx_ch.link_lost <= 1'b0;

		// directed frames
		push_header(TYPE_JOIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12);
		push_header(TYPE_LEAVE, 32'h0000_0000, 32'h0000_0000, 1'b0, 12);
		plan_data_frame(32'h1234_5678, 32'h9ABC_DEF0, 32'd0, 32'd0);    // empty message
		plan_data_frame(32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'd1, 32'd1);    // first and last
		byte_plan[byte_plan.size() - 1].rx_byte = 8'hFF;
		plan_data_frame(32'h0000_0001, 32'h8000_0000, 32'd3, 32'd1);    // abort after first
		plan_data_frame(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'hFFFF_FFFF, 32'd0); // abort before
		push_unknown(32'hFFFF_FFFF, $urandom, $urandom, 0);       // chunk ends with header
		push_unknown(32'h0000_0000, $urandom, $urandom, 2);
		push_header(32'h0000_0010, $urandom, $urandom, 1'b0, 12); // link loss while discarding
		push_byte(8'h00, 1'b0, 1'b0);
		push_lost();
		push_header(TYPE_JOIN, $urandom, $urandom, 1'b0, 5);      // link loss in header
		push_lost();
		push_header(TYPE_DATA, $urandom, $urandom, 1'b0, 14);     // link loss in length
		push_lost();
		directed_n = byte_plan.size();

		// random mix, mostly well-formed frames with random content
		while (byte_plan.size() < directed_n + RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			pa   = $urandom;
			pb   = $urandom;
			if (pick < 15) begin
				push_header(TYPE_JOIN, pa, pb, rand_cend(), 12);
			end else if (pick < 30) begin
				push_header(TYPE_LEAVE, pa, pb, rand_cend(), 12);
			end else if (pick < 70) begin
				cut = $urandom_range(0, 99);
				if (cut < 5) begin
					// random 32-bit length, cut short by a link loss whenever it exceeds sent
					len  = $urandom;
					sent = $urandom_range(0, 4);
				end else if (cut < 25) begin
					len  = $urandom_range(0, 24);
					sent = len;
				end else begin
					len  = $urandom_range(0, 6);
					sent = len;
				end
				if (len > 0 && len < 32'd64 && $urandom_range(0, 9) == 0)
					sent = $urandom_range(0, len - 1);
				plan_data_frame(pa, pb, len, sent);
			end else if (pick < 82) begin
				push_unknown(rand_unknown_type(), pa, pb, $urandom_range(0, 5));
			end else if (pick < 92) begin
				// frame broken off by link loss in header or length
				cut = $urandom_range(0, 15);
				if (cut < 12) begin
					push_header(($urandom_range(0, 1) == 1) ? TYPE_JOIN : TYPE_DATA,
						pa, pb, 1'b0, cut);
				end else begin
					push_header(TYPE_DATA, pa, pb, rand_cend(), 12);
					repeat (cut - 12)
						push_byte(8'($urandom_range(0, 255)), rand_cend(), 1'b0);
				end
				push_lost();
			end else begin
				// noise with random flags, then a link loss to resync
				n = $urandom_range(1, 8);
				repeat (n)
					push_byte(8'($urandom_range(0, 255)), rand_cend(),
						($urandom_range(0, 3) == 0));
				push_lost();
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		i = 0;
		while (byte_plan.size() > 0) begin
			// every fourth stretch of 30 words goes out back to back
			gap = ((i % 120) >= 90) ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			w = byte_plan.pop_front();
			rx_ch.valid     <= 1'b1;
			rx_ch.rx_byte   <= w.rx_byte;
			rx_ch.chunk_end <= w.chunk_end;
			rx_ch.link_lost <= w.link_lost;
			do
				@(posedge clk);
			while (!rx_ch.ready);
			i++;
		end
		rx_ch.valid <= 1'b0;

		// let the checker's count settle, then drain
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("bus_message_deframer: match");
		else
			$display("bus_message_deframer: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// msg side: random stall before each word, two long hold-offs
	// ------------------------------------------------------------------------
	initial begin : msg_receiver
		int unsigned hold;
		int unsigned n;

		msg_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		n = 0;
		forever begin
			if (n == 60 || n == 500)
				hold = LONG_HOLD;
			else if ((n % 100) >= 70)
				hold = 0;
			else
				hold = $urandom_range(0, MAX_GAP);
			if (hold > 0) begin
				msg_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			msg_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!msg_ch.valid);
			n++;
		end
	end

	// hard stop if the run hangs
	initial begin : run_limit
		#(RUN_LIMIT * 2 * HALF_PERIOD);
		$display("bus_message_deframer: mismatch");
		$finish;
	end

endmodule
